>>> hdl/bope_pkg.sv
`default_nettype none
package bope_pkg;

    // Fixed-point constants (Q4.28 for logs and the series)
    localparam logic [27:0] LN2_Q28  = 28'd186065279;
    localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
    localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] CNT_MAX  = 24'hFF_FFFF;
    localparam logic [16:0] DISC_ONE = 17'd65536;

    // Largest series length the reciprocal table supports
    localparam int RECIP_MAX = 40;

    // floor(2^32 / k), used for the divide-by-k of each series term
    localparam logic [32:0] RECIP_TABLE [0:RECIP_MAX] = '{
        33'd0,
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941,
        33'd330382099,  33'd306783378,  33'd286331153,  33'd268435456,
        33'd252645135,  33'd238609294,  33'd226050910,  33'd214748364,
        33'd204522252,  33'd195225786,  33'd186737708,  33'd178956970,
        33'd171798691,  33'd165191049,  33'd159072862,  33'd153391689,
        33'd148102320,  33'd143165576,  33'd138547332,  33'd134217728,
        33'd130150524,  33'd126322567,  33'd122713351,  33'd119304647,
        33'd116080197,  33'd113025455,  33'd110127366,  33'd107374182
    };

    // Configuration register indexes
    localparam logic [2:0] REG_SPOT     = 3'd0;
    localparam logic [2:0] REG_STRIKE   = 3'd1;
    localparam logic [2:0] REG_BARRIER  = 3'd2;
    localparam logic [2:0] REG_DRIFT    = 3'd3;
    localparam logic [2:0] REG_VOL      = 3'd4;
    localparam logic [2:0] REG_STEPS    = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;
    localparam logic [2:0] REG_DISCOUNT = 3'd7;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_STEP_MUL,
        OP_STEP_ACC,
        OP_REDUCE,
        OP_TERM_MUL,
        OP_TERM_REC,
        OP_TERM_COR,
        OP_PRICE_LO,
        OP_PRICE_HI,
        OP_PAYOFF,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   clear;
    } dp_cmd_t;

    typedef struct packed {
        logic path_end;
        logic red_done;
        logic series_done;
    } dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/barrier_option_path_evaluator.sv
// Barrier option path evaluator.
// Input channel (in_valid/in_ready) carries one word per time step: a
// normal_sample and a clear_totals flag that empties the sums and the
// current path before the sample is used.
// Each step registers the product, then adds it and tests the barrier.
// The step that ends a path also runs the path-end sequence: range
// reduction by ln 2 (one subtraction or addition until the range check
// passes), the exponential series over EXP_ITERATIONS terms, 24 by
// default (term multiply, reciprocal multiply, then correction per term),
// price (low and high product), payoff and commit.
// Output channel (out_valid/out_ready) gives one word per finished path.
// A finished word sits in an output register; the block goes on taking
// samples while it waits, and only the next path end stalls until the
// receiver has taken it.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while the block is idle; the block does not enforce it.
// Reset puts the configuration registers to their defaults and clears path, sum and count.
`default_nettype none
module barrier_option_path_evaluator #(
    parameter int MAX_STEPS      = 1024,
    parameter int EXP_ITERATIONS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] normal_sample,
    input  wire logic        clear_totals,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      path_payoff,
    output logic [47:0]      payoff_sum,
    output logic [23:0]      path_count,
    output logic             barrier_hit
);
    import bope_pkg::*;

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic        load_out;
    logic        slot_free;
    logic [31:0] payoff;
    logic [47:0] sum_next;
    logic [23:0] count_next;
    logic        hit;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] payoff_reg;
    logic [47:0] sum_reg;
    logic [23:0] count_reg;
    logic        hit_reg;

    bope_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .clear_totals (clear_totals),
        .slot_free    (slot_free),
        .sts          (sts),
        .cmd          (cmd),
        .in_ready     (in_ready),
        .load_out     (load_out)
    );

    bope_dp #(
        .MAX_STEPS      (MAX_STEPS),
        .EXP_ITERATIONS (EXP_ITERATIONS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .normal_sample (normal_sample),
        .cmd           (cmd),
        .sts           (sts),
        .payoff        (payoff),
        .sum_next      (sum_next),
        .count_next    (count_next),
        .hit           (hit)
    );

    // Output register
    always_comb
    begin
        slot_free = !out_valid_reg || out_ready;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            payoff_reg <= payoff;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            hit_reg    <= hit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign path_payoff = payoff_reg;
    assign payoff_sum  = sum_reg;
    assign path_count  = count_reg;
    assign barrier_hit = hit_reg;

endmodule
`default_nettype wire

>>> hdl/bope_ctrl.sv
`default_nettype none
module bope_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             clear_totals,
    input  wire logic             slot_free,
    input  wire bope_pkg::dp_sts_t sts,
    output bope_pkg::dp_cmd_t     cmd,
    output logic                  in_ready,
    output logic                  load_out
);
    import bope_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_ACC  = 11'b000_0000_0100,
        S_RED  = 11'b000_0000_1000,
        S_TMUL = 11'b000_0001_0000,
        S_TREC = 11'b000_0010_0000,
        S_TCOR = 11'b000_0100_0000,
        S_PLO  = 11'b000_1000_0000,
        S_PHI  = 11'b001_0000_0000,
        S_PAY  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.clear  = 1'b0;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_STEP_MUL;
                    cmd.clear  = clear_totals;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op     = OP_STEP_ACC;
                state_next = sts.path_end ? S_RED : S_IDLE;
            end
            S_ACC:
                state_next = S_RED;
            S_RED:
            begin
                if (sts.red_done)
                    state_next = S_TMUL;
                else
                    cmd.op = OP_REDUCE;
            end
            S_TMUL:
            begin
                cmd.op     = OP_TERM_MUL;
                state_next = S_TREC;
            end
            S_TREC:
            begin
                cmd.op     = OP_TERM_REC;
                state_next = S_TCOR;
            end
            S_TCOR:
            begin
                cmd.op     = OP_TERM_COR;
                state_next = sts.series_done ? S_PLO : S_TMUL;
            end
            S_PLO:
            begin
                cmd.op     = OP_PRICE_LO;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                cmd.op     = OP_PRICE_HI;
                state_next = S_PAY;
            end
            S_PAY:
            begin
                cmd.op     = OP_PAYOFF;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.op     = OP_COMMIT;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/bope_dp.sv
`default_nettype none
module bope_dp #(
    parameter int MAX_STEPS      = 1024,
    parameter int EXP_ITERATIONS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic [15:0]       normal_sample,
    input  wire bope_pkg::dp_cmd_t cmd,
    output bope_pkg::dp_sts_t      sts,
    output logic [31:0]            payoff,
    output logic [47:0]            sum_next,
    output logic [23:0]            count_next,
    output logic                   hit
);
    import bope_pkg::*;

    localparam int KW = $clog2(EXP_ITERATIONS + 1);
    localparam logic [16:0] MAX_STEPS_W = 17'(MAX_STEPS);
    localparam logic [KW-1:0] K_LAST = KW'(EXP_ITERATIONS);

    // Configuration registers
    logic [31:0] spot_reg, strike_reg;
    logic signed [31:0] barrier_reg, drift_reg;
    logic [30:0] vol_reg;
    logic [10:0] steps_reg;
    logic [2:0]  mode_reg;
    logic [16:0] disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_reg    <= 32'd6553600;
            strike_reg  <= 32'd6881280;
            barrier_reg <= 32'sd18162263;
            drift_reg   <= 32'sd268435;
            vol_reg     <= 31'd16977268;
            steps_reg   <= 11'd10;
            mode_reg    <= 3'd0;
            disc_reg    <= 17'd61719;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPOT:     spot_reg    <= cfg_data;
                REG_STRIKE:   strike_reg  <= cfg_data;
                REG_BARRIER:  barrier_reg <= cfg_data;
                REG_DRIFT:    drift_reg   <= cfg_data;
                REG_VOL:      vol_reg     <= cfg_data[30:0];
                REG_STEPS:    steps_reg   <= cfg_data[10:0];
                REG_MODE:     mode_reg    <= cfg_data[2:0];
                REG_DISCOUNT: disc_reg    <= cfg_data[16:0];
                default:      spot_reg    <= spot_reg;
            endcase
        end
    end

    // Path and totals state
    logic signed [31:0] log_reg;
    logic               crossed_reg;
    logic [10:0]        step_reg;
    logic [47:0]        sum_reg;
    logic [23:0]        cnt_reg;

    // Working registers
    logic signed [47:0] sprod_reg;
    logic signed [31:0] f_reg;
    logic signed [4:0]  n_reg;
    logic               hit_reg;
    logic [28:0]        term_reg;
    logic [29:0]        e_reg;
    logic [KW-1:0]      k_reg;
    logic [56:0]        tprod_reg;
    logic [28:0]        a_reg;
    logic [61:0]        qe_reg;
    logic [47:0]        plo_reg;
    logic [31:0]        price_reg;
    logic [31:0]        payoff_reg;

    // Step arithmetic: floor of the scaled product, saturating add, barrier test and step bound
    logic signed [35:0] inc;
    logic signed [37:0] nv_wide;
    logic signed [31:0] nv;
    logic               hit_now;
    logic [16:0]        steps_eff;
    logic [16:0]        step_inc;

    always_comb
    begin
        inc     = sprod_reg[47:12];
        nv_wide = 38'(log_reg) + 38'(drift_reg) + 38'(inc);
        if (nv_wide > 38'sd2147483647)
            nv = 32'sh7FFF_FFFF;
        else if (nv_wide < -38'sd2147483648)
            nv = 32'sh8000_0000;
        else
            nv = nv_wide[31:0];
        if (mode_reg[1])
            hit_now = crossed_reg | (nv >= barrier_reg);
        else
            hit_now = crossed_reg | (nv <= barrier_reg);
        if (steps_reg == 11'd0)
            steps_eff = 17'd1;
        else if (17'(steps_reg) > MAX_STEPS_W)
            steps_eff = MAX_STEPS_W;
        else
            steps_eff = 17'(steps_reg);
        step_inc = 17'(step_reg) + 17'd1;
    end

    // Divide-by-k correction, the price shift, the payoff and the saturating totals
    logic [28:0] q0, q1;
    logic [34:0] qk;
    logic [28:0] rem;
    logic [5:0]  kidx;
    logic signed [6:0] sh_s;
    logic [61:0] full_prod, shifted;
    logic [31:0] price_sat;
    logic [31:0] intrinsic;
    logic [16:0] disc_eff;
    logic [48:0] pay_prod;
    logic        pays;
    logic [48:0] sum_wide;

    always_comb
    begin
        kidx = 6'(k_reg);
        q0   = qe_reg[60:32];
        qk   = 35'(q0) * 35'(k_reg);
        rem  = a_reg - qk[28:0];
        q1   = (rem >= 29'(k_reg)) ? q0 + 29'd1 : q0;

        sh_s      = 7'sd28 - {{2{n_reg[4]}}, n_reg};
        full_prod = 62'(plo_reg) + (62'(64'(spot_reg) * 64'(e_reg[29:16])) << 16);
        shifted   = full_prod >> sh_s[5:0];
        price_sat = (|shifted[61:32]) ? 32'hFFFF_FFFF : shifted[31:0];

        if (mode_reg[0])
            intrinsic = (price_reg > strike_reg) ? price_reg - strike_reg : 32'd0;
        else
            intrinsic = (strike_reg > price_reg) ? strike_reg - price_reg : 32'd0;
        pays     = mode_reg[2] ? hit_reg : !hit_reg;
        disc_eff = (disc_reg > DISC_ONE) ? DISC_ONE : disc_reg;
        pay_prod = 49'(intrinsic) * 49'(disc_eff);

        sum_wide   = 49'(sum_reg) + 49'(payoff_reg);
        sum_next   = sum_wide[48] ? SUM_MAX : sum_wide[47:0];
        count_next = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + 24'd1;
    end

    // Control state of the path and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_reg     <= '0;
            crossed_reg <= 1'b0;
            step_reg    <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_STEP_MUL:
                begin
                    if (cmd.clear)
                    begin
                        log_reg     <= '0;
                        crossed_reg <= 1'b0;
                        step_reg    <= '0;
                        sum_reg     <= '0;
                        cnt_reg     <= '0;
                    end
                end
                OP_STEP_ACC:
                begin
                    if (sts.path_end)
                    begin
                        log_reg     <= '0;
                        crossed_reg <= 1'b0;
                        step_reg    <= '0;
                    end
                    else
                    begin
                        log_reg     <= nv;
                        crossed_reg <= hit_now;
                        step_reg    <= step_inc[10:0];
                    end
                end
                OP_COMMIT:
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= count_next;
                end
                default:
                    step_reg <= step_reg;
            endcase
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_STEP_MUL:
                sprod_reg <= 48'(signed'({1'b0, vol_reg})) * 48'(signed'(normal_sample));
            OP_STEP_ACC:
            begin
                f_reg    <= nv;
                n_reg    <= '0;
                hit_reg  <= hit_now;
                term_reg <= ONE_Q28;
                e_reg    <= 30'(ONE_Q28);
                k_reg    <= KW'(1);
            end
            // one subtraction or addition of ln 2 per cycle
            OP_REDUCE:
            begin
                if (f_reg < 0)
                begin
                    f_reg <= f_reg + 32'(LN2_Q28);
                    n_reg <= n_reg - 5'sd1;
                end
                else
                begin
                    f_reg <= f_reg - 32'(LN2_Q28);
                    n_reg <= n_reg + 5'sd1;
                end
            end
            OP_TERM_MUL:
                tprod_reg <= 57'(term_reg) * 57'(f_reg[27:0]);
            OP_TERM_REC:
            begin
                a_reg  <= tprod_reg[56:28];
                qe_reg <= 62'(tprod_reg[56:28]) * 62'(RECIP_TABLE[kidx]);
            end
            OP_TERM_COR:
            begin
                term_reg <= q1;
                e_reg    <= e_reg + 30'(q1);
                k_reg    <= k_reg + KW'(1);
            end
            OP_PRICE_LO:
                plo_reg <= 48'(spot_reg) * 48'(e_reg[15:0]);
            OP_PRICE_HI:
                price_reg <= price_sat;
            OP_PAYOFF:
                payoff_reg <= pays ? pay_prod[47:16] : 32'd0;
            default:
                term_reg <= term_reg;
        endcase
    end

    always_comb
    begin
        sts.path_end    = step_inc >= steps_eff;
        sts.red_done    = (f_reg >= 0) && (f_reg < 32'sd186065279);
        sts.series_done = (k_reg == K_LAST);
        payoff          = payoff_reg;
        hit             = hit_reg;
    end

endmodule
`default_nettype wire

>>> hdl/bope_checker.sv
`default_nettype none
module bope_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] path_payoff,
    input wire logic [47:0] payoff_sum,
    input wire logic [23:0] path_count
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(path_payoff)
            && $stable(payoff_sum) && $stable(path_count))
        else $error("result word changed while stalled");

    // A taken step keeps the block busy, so input is not accepted back to back
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // A new result is only loaded while no input is taken
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared from an idle state");

    // Every result counts at least one path
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> path_count != 24'd0)
        else $error("result with zero path count");

endmodule

bind barrier_option_path_evaluator bope_checker u_bope_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .path_payoff (path_payoff),
    .payoff_sum  (payoff_sum),
    .path_count  (path_count)
);
`default_nettype wire
